// File: sv/bttf_pkg.sv
// Shared types and constants for the boundary-tag first-fit allocator.
package bttf_pkg;

   localparam int unsigned HDR_BYTES = 9;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;
   localparam logic [1:0] STATUS_IS_FREE  = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [15:0] alloc_size;
      logic [15:0] free_address;
   } req_type;

   typedef struct packed {
      logic [15:0] granted_address;
      logic [1:0]  status;
   } rsp_type;

   // One chunk header as held in the tag stores.
   typedef struct packed {
      logic [15:0] size;
      logic [15:0] left;
      logic        mark;
      logic [15:0] next;
      logic [15:0] prev;
   } chunk_rec_type;

   // Per-field write enables for one header write.
   typedef struct packed {
      logic size;
      logic left;
      logic mark;
      logic next;
      logic prev;
   } field_mask_type;

   typedef struct packed {
      field_mask_type mask;
      logic [15:0]    addr;
      chunk_rec_type  rec;
   } wr_port_type;

endpackage

// File: sv/bttf_store.sv
// Header tag stores: one write port with field enables, one registered read port.
module bttf_store #(
   parameter int unsigned DEPTH = 65536
) (
   input  logic                   clock,
   input  bttf_pkg::wr_port_type  wr,
   input  logic [15:0]            rd_addr,
   output bttf_pkg::chunk_rec_type rd_data
);
   import bttf_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic [15:0] size_mem [DEPTH];
   logic [15:0] left_mem [DEPTH];
   logic        mark_mem [DEPTH];
   logic [15:0] next_mem [DEPTH];
   logic [15:0] prev_mem [DEPTH];

   chunk_rec_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr.mask.size) size_mem[wr.addr[AW-1:0]] <= wr.rec.size;
      if (wr.mask.left) left_mem[wr.addr[AW-1:0]] <= wr.rec.left;
      if (wr.mask.mark) mark_mem[wr.addr[AW-1:0]] <= wr.rec.mark;
      if (wr.mask.next) next_mem[wr.addr[AW-1:0]] <= wr.rec.next;
      if (wr.mask.prev) prev_mem[wr.addr[AW-1:0]] <= wr.rec.prev;
   end

   always_ff @(posedge clock) begin
      rd_ff.size <= size_mem[rd_addr[AW-1:0]];
      rd_ff.left <= left_mem[rd_addr[AW-1:0]];
      rd_ff.mark <= mark_mem[rd_addr[AW-1:0]];
      rd_ff.next <= next_mem[rd_addr[AW-1:0]];
      rd_ff.prev <= prev_mem[rd_addr[AW-1:0]];
   end

   assign rd_data = rd_ff;

endmodule

// File: sv/boundary_tag_first_fit_allocator.sv
// Top level of the boundary-tag first-fit heap allocator with its request sequencer.
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_stall | operation, alloc_size, free_address
//   rsp     | out       | rsp_valid/rsp_stall | granted_address, status
//
// An allocate reads one header per free-list entry visited, then reports no space,
// unlinks the chosen chunk or splits it. A free rejects an out-of-range address
// without a store access, stops after one header read for a chunk that is already
// free, and otherwise releases and merges the chunk, all paced by the store's single
// write port.
// After reset, the initial header at index 1 is written before req is taken.
// A finished result sits in an output register; the sequencer only waits when that
// register is still full at the end of the next request.
module boundary_tag_first_fit_allocator #(
   parameter int unsigned HEAP_BYTES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bttf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bttf_pkg::rsp_type rsp_data
);
   import bttf_pkg::*;

   // The step counter must be able to hold HEAP_BYTES itself.
   localparam int unsigned SW = $clog2(HEAP_BYTES + 1);
   localparam logic [16:0] HEAP_L = 17'(HEAP_BYTES);
   localparam logic [SW-1:0] STEP_LIMIT = SW'(HEAP_BYTES);

   typedef enum logic [32:0] {
      ST_INIT   = 33'd1 << 0,
      ST_IDLE   = 33'd1 << 1,
      ST_A_CHK  = 33'd1 << 2,
      ST_A_DAT  = 33'd1 << 3,
      ST_A_SP1  = 33'd1 << 4,
      ST_A_SP2  = 33'd1 << 5,
      ST_A_SP3  = 33'd1 << 6,
      ST_A_SP4  = 33'd1 << 7,
      ST_A_SP5  = 33'd1 << 8,
      ST_F_RD0  = 33'd1 << 9,
      ST_F_MARK = 33'd1 << 10,
      ST_F_RD1  = 33'd1 << 11,
      ST_F_LS   = 33'd1 << 12,
      ST_F_RDL  = 33'd1 << 13,
      ST_F_ML   = 33'd1 << 14,
      ST_F_M2   = 33'd1 << 15,
      ST_F_M3   = 33'd1 << 16,
      ST_F_M4   = 33'd1 << 17,
      ST_F_RDC  = 33'd1 << 18,
      ST_F_END  = 33'd1 << 19,
      ST_F_RDE  = 33'd1 << 20,
      ST_F_ME   = 33'd1 << 21,
      ST_F_R2   = 33'd1 << 22,
      ST_F_R3   = 33'd1 << 23,
      ST_F_RDF  = 33'd1 << 24,
      ST_F_LAST = 33'd1 << 25,
      ST_RM_RD  = 33'd1 << 26,
      ST_RM_WR  = 33'd1 << 27,
      ST_RM_N   = 33'd1 << 28,
      ST_RM_P   = 33'd1 << 29,
      ST_PU_A   = 33'd1 << 30,
      ST_PU_B   = 33'd1 << 31,
      ST_DONE   = 33'd1 << 32
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   // Working registers of the sequencer.
   logic [15:0]   head_ff, head_in;
   logic [15:0]   x_ff, x_in;          // argument of the unlink and push routines
   logic [15:0]   c_ff, c_in;          // chunk being freed
   logic [15:0]   l_ff, l_in;          // left neighbor
   logic [15:0]   e_ff, e_in;          // right neighbor
   logic [15:0]   sz_ff, sz_in;        // captured chunk size
   logic [15:0]   n_ff, n_in;          // captured next link
   logic [15:0]   pv_ff, pv_in;        // captured prev link
   logic [15:0]   p_ff, p_in;          // walk pointer
   logic [16:0]   need_ff, need_in;    // header plus payload
   logic [SW-1:0] steps_ff, steps_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   wr_port_type   wr;
   logic [15:0]   rd_addr;
   chunk_rec_type rd_data;

   bttf_store #(.DEPTH(HEAP_BYTES)) u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Free-side address checks and split arithmetic.
   logic [15:0] fa_chunk;
   logic [15:0] split_r;
   logic [15:0] split_rem;
   logic [16:0] split_end;
   logic [16:0] sum_end;
   logic [15:0] left_idx;
   logic [17:0] split_need;

   assign fa_chunk   = req_data.free_address - 16'(HDR_BYTES);
   assign split_r    = p_ff + need_ff[15:0];
   assign split_rem  = sz_ff - need_ff[15:0];
   assign split_end  = {1'b0, split_r} + {1'b0, split_rem};
   assign sum_end    = {1'b0, c_ff} + {1'b0, rd_data.size};
   assign left_idx   = c_ff - rd_data.left;
   assign split_need = {1'b0, need_ff} + 18'(HDR_BYTES + 1);

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      head_in     = head_ff;
      x_in        = x_ff;
      c_in        = c_ff;
      l_in        = l_ff;
      e_in        = e_ff;
      sz_in       = sz_ff;
      n_in        = n_ff;
      pv_in       = pv_ff;
      p_in        = p_ff;
      need_in     = need_ff;
      steps_in    = steps_ff;
      res_in      = res_ff;
      rd_addr     = 16'd0;
      wr          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_INIT: begin
            // Index 1 starts as one free chunk covering the heap.
            wr.mask     = '1;
            wr.addr     = 16'd1;
            wr.rec.size = 16'(HEAP_BYTES - 1);
            wr.rec.mark = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               if (req_data.operation == OP_ALLOC) begin
                  need_in  = 17'(HDR_BYTES) + {1'b0, req_data.alloc_size};
                  p_in     = head_ff;
                  steps_in = '0;
                  state_in = ST_A_CHK;
               end else if (req_data.free_address < 16'(HDR_BYTES + 1) ||
                            {1'b0, fa_chunk} >= HEAP_L) begin
                  res_in.status = STATUS_BAD_ADDR;
                  state_in      = ST_DONE;
               end else begin
                  c_in     = fa_chunk;
                  state_in = ST_F_RD0;
               end
            end
         end
         ST_A_CHK: begin
            if (p_ff == 16'd0 || steps_ff == STEP_LIMIT) begin
               res_in.status = STATUS_NO_SPACE;
               state_in      = ST_DONE;
            end else begin
               rd_addr  = p_ff;
               state_in = ST_A_DAT;
            end
         end
         ST_A_DAT: begin
            if ({1'b0, rd_data.size} >= need_ff) begin
               res_in.granted_address = p_ff + 16'(HDR_BYTES);
               res_in.status          = STATUS_OK;
               if ({2'b0, rd_data.size} >= split_need) begin
                  sz_in    = rd_data.size;
                  n_in     = rd_data.next;
                  pv_in    = rd_data.prev;
                  state_in = ST_A_SP1;
               end else begin
                  x_in     = p_ff;
                  ret_in   = ST_DONE;
                  state_in = ST_RM_RD;
               end
            end else begin
               p_in     = rd_data.next;
               steps_in = steps_ff + 1'b1;
               state_in = ST_A_CHK;
            end
         end
         ST_A_SP1: begin
            wr.mask.size = 1'b1;
            wr.mask.mark = 1'b1;
            wr.addr      = p_ff;
            wr.rec.size  = need_ff[15:0];
            state_in     = ST_A_SP2;
         end
         ST_A_SP2: begin
            wr.mask     = '1;
            wr.addr     = split_r;
            wr.rec.size = split_rem;
            wr.rec.left = need_ff[15:0];
            wr.rec.mark = 1'b1;
            wr.rec.next = n_ff;
            wr.rec.prev = pv_ff;
            state_in    = ST_A_SP3;
         end
         ST_A_SP3: begin
            if (n_ff != 16'd0) begin
               wr.mask.prev = 1'b1;
               wr.addr      = n_ff;
               wr.rec.prev  = split_r;
            end
            state_in = ST_A_SP4;
         end
         ST_A_SP4: begin
            if (pv_ff != 16'd0) begin
               wr.mask.next = 1'b1;
               wr.addr      = pv_ff;
               wr.rec.next  = split_r;
            end
            if (head_ff == p_ff) head_in = split_r;
            state_in = ST_A_SP5;
         end
         ST_A_SP5: begin
            if (split_end < HEAP_L) begin
               wr.mask.left = 1'b1;
               wr.addr      = split_end[15:0];
               wr.rec.left  = split_rem;
            end
            state_in = ST_DONE;
         end
         ST_F_RD0: begin
            rd_addr  = c_ff;
            state_in = ST_F_MARK;
         end
         ST_F_MARK: begin
            if (rd_data.mark) begin
               res_in.status = STATUS_IS_FREE;
               state_in      = ST_DONE;
            end else begin
               x_in     = c_ff;
               ret_in   = ST_F_RD1;
               state_in = ST_PU_A;
            end
         end
         ST_F_RD1: begin
            rd_addr  = c_ff;
            state_in = ST_F_LS;
         end
         ST_F_LS: begin
            sz_in = rd_data.size;
            l_in  = left_idx;
            if (rd_data.left != 16'd0 && left_idx != 16'd0 &&
                {1'b0, left_idx} < HEAP_L) begin
               state_in = ST_F_RDL;
            end else begin
               state_in = ST_F_RDC;
            end
         end
         ST_F_RDL: begin
            rd_addr  = l_ff;
            state_in = ST_F_ML;
         end
         ST_F_ML: begin
            if (rd_data.mark) begin
               wr.mask.size = 1'b1;
               wr.addr      = l_ff;
               wr.rec.size  = rd_data.size + sz_ff;
               x_in         = c_ff;
               ret_in       = ST_F_M2;
               state_in     = ST_RM_RD;
            end else begin
               state_in = ST_F_RDC;
            end
         end
         ST_F_M2: begin
            x_in     = l_ff;
            ret_in   = ST_F_M3;
            state_in = ST_RM_RD;
         end
         ST_F_M3: begin
            x_in     = l_ff;
            ret_in   = ST_F_M4;
            state_in = ST_PU_A;
         end
         ST_F_M4: begin
            c_in     = l_ff;
            state_in = ST_F_RDC;
         end
         ST_F_RDC: begin
            rd_addr  = c_ff;
            state_in = ST_F_END;
         end
         ST_F_END: begin
            sz_in = rd_data.size;
            e_in  = sum_end[15:0];
            if (sum_end < HEAP_L && sum_end != 17'd0) begin
               state_in = ST_F_RDE;
            end else begin
               state_in = ST_F_RDF;
            end
         end
         ST_F_RDE: begin
            rd_addr  = e_ff;
            state_in = ST_F_ME;
         end
         ST_F_ME: begin
            if (rd_data.mark) begin
               wr.mask.size = 1'b1;
               wr.addr      = c_ff;
               wr.rec.size  = sz_ff + rd_data.size;
               x_in         = e_ff;
               ret_in       = ST_F_R2;
               state_in     = ST_RM_RD;
            end else begin
               state_in = ST_F_RDF;
            end
         end
         ST_F_R2: begin
            x_in     = c_ff;
            ret_in   = ST_F_R3;
            state_in = ST_RM_RD;
         end
         ST_F_R3: begin
            x_in     = c_ff;
            ret_in   = ST_F_RDF;
            state_in = ST_PU_A;
         end
         ST_F_RDF: begin
            rd_addr  = c_ff;
            state_in = ST_F_LAST;
         end
         ST_F_LAST: begin
            // Refresh the right neighbor's copy of this chunk's size.
            if (sum_end < HEAP_L) begin
               wr.mask.left = 1'b1;
               wr.addr      = sum_end[15:0];
               wr.rec.left  = rd_data.size;
            end
            res_in.status = STATUS_OK;
            state_in      = ST_DONE;
         end
         ST_RM_RD: begin
            rd_addr  = x_ff;
            state_in = ST_RM_WR;
         end
         ST_RM_WR: begin
            n_in         = rd_data.next;
            pv_in        = rd_data.prev;
            wr.mask.mark = 1'b1;
            wr.mask.next = 1'b1;
            wr.mask.prev = 1'b1;
            wr.addr      = x_ff;
            state_in     = ST_RM_N;
         end
         ST_RM_N: begin
            if (n_ff != 16'd0) begin
               wr.mask.prev = 1'b1;
               wr.addr      = n_ff;
               wr.rec.prev  = pv_ff;
            end
            state_in = ST_RM_P;
         end
         ST_RM_P: begin
            if (pv_ff != 16'd0) begin
               wr.mask.next = 1'b1;
               wr.addr      = pv_ff;
               wr.rec.next  = n_ff;
            end
            if (head_ff == x_ff) head_in = n_ff;
            state_in = ret_ff;
         end
         ST_PU_A: begin
            wr.mask.mark = 1'b1;
            wr.mask.next = 1'b1;
            wr.mask.prev = 1'b1;
            wr.addr      = x_ff;
            wr.rec.mark  = 1'b1;
            wr.rec.next  = head_ff;
            state_in     = ST_PU_B;
         end
         ST_PU_B: begin
            if (head_ff != 16'd0) begin
               wr.mask.prev = 1'b1;
               wr.addr      = head_ff;
               wr.rec.prev  = x_ff;
            end
            head_in  = x_ff;
            state_in = ret_ff;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is empty or draining.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ret_ff       <= ST_DONE;
         head_ff      <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      c_ff        <= c_in;
      l_ff        <= l_in;
      e_ff        <= e_in;
      sz_ff       <= sz_in;
      n_ff        <= n_in;
      pv_ff       <= pv_in;
      p_ff        <= p_in;
      need_ff     <= need_in;
      steps_ff    <= steps_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A granted address only comes with a successful status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.granted_address == 16'd0)
      else $error("granted address on a failed request");

   // The first-fit walk never runs past its step bound.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_A_CHK |-> steps_ff <= STEP_LIMIT)
      else $error("free-list walk overran its bound");

   // An accepted request always starts the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("request transfer did not start the sequencer");

   // A result is loaded only when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid_ff && rsp_stall |=> state_ff == ST_DONE)
      else $error("result dropped while output was stalled");

endmodule

// File: verif/tb_boundary_tag_first_fit_allocator.sv
// Self-checking testbench for the boundary-tag first-fit heap allocator.
module tb_boundary_tag_first_fit_allocator;
   import bttf_pkg::*;

   // The scoreboard keeps its own copy of the heap tags and free list. Each accepted
   // request is run through that copy, and the predicted response is queued for the
   // response monitor. It also tracks which payload addresses are currently granted,
   // so that the stimulus can free real chunk starts.
   class alloc_scoreboard;
      bit [15:0]   tag_size [65536];
      bit [15:0]   tag_left [65536];
      bit [15:0]   tag_next [65536];
      bit [15:0]   tag_prev [65536];
      bit          tag_free [65536];
      bit [15:0]   list_head;
      rsp_type     pending_rsp [$];
      int unsigned granted [$];
      int          mismatches;
      int          checked;
      int          noted;

      function new();
         tag_size[1] = 16'hFFFF;
         tag_free[1] = 1'b1;
         list_head   = 16'd1;
      endfunction

      function void unlink(int unsigned x);
         int unsigned n, p;
         n = tag_next[x];
         p = tag_prev[x];
         tag_free[x] = 1'b0;
         tag_next[x] = '0;
         tag_prev[x] = '0;
         if (n != 0) tag_prev[n] = p[15:0];
         if (p != 0) tag_next[p] = n[15:0];
         if (list_head == x) list_head = n[15:0];
      endfunction

      function void push_head(int unsigned x);
         tag_free[x] = 1'b1;
         tag_prev[x] = '0;
         tag_next[x] = list_head;
         if (list_head != 0) tag_prev[list_head] = x[15:0];
         list_head = x[15:0];
      endfunction

      // First-fit walk from the list head; splits when a header plus one byte is left.
      function rsp_type first_fit(int unsigned req_bytes);
         rsp_type     res;
         int unsigned need, p, steps, sz, rem, r, n, pv;
         need  = HDR_BYTES + req_bytes;
         p     = list_head;
         steps = 0;
         res.granted_address = '0;
         res.status          = STATUS_NO_SPACE;
         while (p != 0 && steps < 65536) begin
            sz = tag_size[p];
            if (sz >= need) begin
               if (sz >= need + HDR_BYTES + 1) begin
                  rem = sz - need;
                  r   = (p + need) & 16'hFFFF;
                  tag_size[p] = need[15:0];
                  tag_free[p] = 1'b0;
                  tag_free[r] = 1'b1;
                  tag_size[r] = rem[15:0];
                  tag_left[r] = need[15:0];
                  n = tag_next[p];
                  tag_next[r] = n[15:0];
                  if (n != 0) tag_prev[n] = r[15:0];
                  pv = tag_prev[p];
                  tag_prev[r] = pv[15:0];
                  if (pv != 0) tag_next[pv] = r[15:0];
                  if (list_head == p) list_head = r[15:0];
                  if (r + rem < 65536) tag_left[r + rem] = rem[15:0];
               end else begin
                  unlink(p);
               end
               res.granted_address = 16'(p + HDR_BYTES);
               res.status          = STATUS_OK;
               return res;
            end
            p = tag_next[p];
            steps++;
         end
         return res;
      endfunction

      // Release with merging into free neighbors on both sides.
      function logic [1:0] release_chunk(int unsigned addr);
         int unsigned c, ls, l, fin;
         if (addr < HDR_BYTES + 1) return STATUS_BAD_ADDR;
         c = addr - HDR_BYTES;
         if (c > 65535) return STATUS_BAD_ADDR;
         if (tag_free[c]) return STATUS_IS_FREE;
         push_head(c);
         ls = tag_left[c];
         if (ls != 0) begin
            l = (c + 65536 - ls) & 16'hFFFF;
            if (l != 0 && tag_free[l]) begin
               tag_size[l] = tag_size[l] + tag_size[c];
               unlink(c);
               unlink(l);
               push_head(l);
               c = l;
            end
         end
         fin = c + tag_size[c];
         if (fin < 65536 && fin != 0 && tag_free[fin]) begin
            tag_size[c] = tag_size[c] + tag_size[fin];
            unlink(fin);
            unlink(c);
            push_head(c);
         end
         fin = c + tag_size[c];
         if (fin < 65536) tag_left[fin] = tag_size[c];
         return STATUS_OK;
      endfunction

      function void note_request(req_type r);
         rsp_type res;
         noted++;
         if (r.operation == OP_ALLOC) begin
            res = first_fit(r.alloc_size);
            if (res.status == STATUS_OK) granted.push_back(res.granted_address);
         end else begin
            res.granted_address = '0;
            res.status          = release_chunk(r.free_address);
            if (res.status == STATUS_OK)
               foreach (granted[i])
                  if (granted[i] == r.free_address) begin
                     granted.delete(i);
                     break;
                  end
         end
         pending_rsp.push_back(res);
      endfunction

      task report(string msg);
         mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected response addr=%0d status=%0d",
                             got.granted_address, got.status));
            return;
         end
         want = pending_rsp.pop_front();
         checked++;
         if (got.granted_address !== want.granted_address)
            report($sformatf("response %0d granted_address %0d, expected %0d",
                             checked, got.granted_address, want.granted_address));
         if (got.status !== want.status)
            report($sformatf("response %0d status %0d, expected %0d",
                             checked, got.status, want.status));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   alloc_scoreboard heap_sb;

   // Percent chance per cycle that the sender idles or the receiver stalls.
   int sender_idle_pct;
   int receiver_stall_pct;

   boundary_tag_first_fit_allocator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver stalls at random; stall changes only at the rising edge.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Outputs are sampled right after the edge, so the values seen are the ones that
   // were present at the edge. That makes a response transfer unambiguous.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) heap_sb.check_response(rsp_data);
   end

   // Presents one request and holds it until the transfer happens. The valid stays
   // high across back-to-back transfers, so it is never dropped and raised in one step.
   task send_request(req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      heap_sb.note_request(r);
   endtask

   task send_alloc(int unsigned bytes);
      req_type r;
      r.operation    = OP_ALLOC;
      r.alloc_size   = bytes[15:0];
      r.free_address = 16'($urandom());
      send_request(r);
   endtask

   task send_free(int unsigned addr);
      req_type r;
      r.operation    = OP_FREE;
      r.alloc_size   = 16'($urandom());
      r.free_address = addr[15:0];
      send_request(r);
   endtask

   // One random request. Most traffic is allocates and frees of live chunks. The
   // live set is capped, so the free list stays short and allocate walks stay bounded.
   // The rest are low addresses and repeated frees of chunks that are already free.
   task send_random;
      int unsigned pick, bytes, live;
      pick = $urandom_range(99);
      live = heap_sb.granted.size();
      if (pick < 5) begin
         send_free($urandom_range(HDR_BYTES));
      end else if (pick < 10 && heap_sb.list_head != 0) begin
         send_free(heap_sb.list_head + HDR_BYTES);
      end else if (live > 0 && (live >= 40 || pick < 50)) begin
         send_free(heap_sb.granted[$urandom_range(live - 1)]);
      end else begin
         pick = $urandom_range(99);
         if (pick < 80)      bytes = $urandom_range(300);
         else if (pick < 95) bytes = $urandom_range(4000);
         else                bytes = $urandom_range(65535);
         send_alloc(bytes);
      end
   endtask

   task wait_for_drain;
      while (heap_sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      heap_sb            = new();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      rsp_stall          = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The heap is taken whole, and an oversize request fails.
      // Frees of low addresses and double frees are rejected. Then the two halves
      // are freed so that the second merges into the first.
      send_alloc(65535);
      send_alloc(65526);
      send_alloc(0);
      send_free(10);
      send_free(10);
      send_free(0);
      send_free(9);
      send_alloc(0);
      send_alloc(65517);
      send_alloc(1);
      send_free(10);
      send_free(19);
      send_alloc(100);
      send_alloc(200);
      send_alloc(50);
      send_free(119);
      send_free(10);
      send_free(328);
      send_alloc(65526);
      send_free(10);
      req_valid <= 1'b0;
      wait_for_drain();

      // Random part in four phases with different idling and stalling rates. After the first phase the sender pauses
      // until every outstanding response has come back.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
            default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
         endcase
         repeat (170) send_random();
         if (phase == 0) begin
            req_valid <= 1'b0;
            wait_for_drain();
         end
      end
      req_valid <= 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      wait_for_drain();
      repeat (100) @(posedge clock);

      $display("Sent %0d allocate and free requests with random idling and stalling;",
               heap_sb.noted);
      $display("checked %0d responses, %0d chunks still granted at the end.",
               heap_sb.checked, heap_sb.granted.size());
      if (heap_sb.mismatches == 0 && heap_sb.pending_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog for a block that stops responding.
   initial begin
      #30000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
